// File: rtl/clts_pkg.sv
`default_nettype none

package clts_pkg;

   typedef logic [7:0] bcd_type;

   localparam int NumFields = 7;
   localparam int FieldWidth = 3;

   typedef logic [NumFields-1:0][7:0] copy_type;

   localparam logic [FieldWidth-1:0] FieldYear    = 3'd0;
   localparam logic [FieldWidth-1:0] FieldMonth   = 3'd1;
   localparam logic [FieldWidth-1:0] FieldDay     = 3'd2;
   localparam logic [FieldWidth-1:0] FieldHour    = 3'd3;
   localparam logic [FieldWidth-1:0] FieldMinute  = 3'd4;
   localparam logic [FieldWidth-1:0] FieldSecond  = 3'd5;
   localparam logic [FieldWidth-1:0] FieldWeekday = 3'd6;
   localparam logic [FieldWidth-1:0] LastField    = FieldWeekday;

   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 16;
   localparam logic [CsrIndexWidth-1:0] RegBlinkStep  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] RegBlinkLimit = 1'b1;

   localparam logic [7:0]  BlinkStepReset  = 8'd20;
   localparam logic [15:0] BlinkLimitReset = 16'd250;

   typedef struct packed {
      logic                     we;
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0]  data;
   } csr_write_type;

   // request word, lowest bits at the bottom of the struct
   typedef struct packed {
      logic [5:0] pad;
      bcd_type    rtc_year;
      bcd_type    rtc_weekday;
      bcd_type    rtc_month;
      bcd_type    rtc_day;
      bcd_type    rtc_hour;
      bcd_type    rtc_minute;
      bcd_type    rtc_second;
      logic       set_pressed;
      logic       up_pressed;
   } req_word_type;

   typedef struct packed {
      logic [1:0]            pad;
      bcd_type               shown_year;
      bcd_type               shown_weekday;
      bcd_type               shown_month;
      bcd_type               shown_day;
      bcd_type               shown_hour;
      bcd_type               shown_minute;
      bcd_type               shown_second;
      logic                  save_strobe;
      logic                  blink_phase;
      logic [FieldWidth-1:0] field_index;
      logic                  editing;
   } rsp_word_type;

   // high nibble * 10 + low nibble, up to 165
   function automatic logic [7:0] bcd_value(input bcd_type b);
      return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
   endfunction

   // v is at most 99 here; tens by reciprocal multiply
   function automatic bcd_type to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

`default_nettype wire

// File: rtl/clts_bump.sv
`default_nettype none

module clts_bump
   import clts_pkg::*;
(
   input  wire copy_type              copy,
   input  wire logic [FieldWidth-1:0] field,
   output bcd_type                    bumped
);

   logic [7:0] year_val;
   logic [7:0] month_val;
   logic       leap;
   logic [7:0] day_limit;
   bcd_type    cur;
   logic [7:0] limit;
   logic [7:0] wrap_to;
   logic [7:0] next_val;

   assign year_val  = bcd_value(copy[FieldYear]);
   assign month_val = bcd_value(copy[FieldMonth]);
   // years 2000..2165: 2100 is the only century year that is not a leap year
   assign leap = (year_val[1:0] == 2'd0) && (year_val != 8'd100);

   always_comb begin
      if (month_val == 8'd2) begin
         day_limit = leap ? 8'd29 : 8'd28;
      end else if (month_val inside {8'd4, 8'd6, 8'd9, 8'd11}) begin
         day_limit = 8'd30;
      end else begin
         day_limit = 8'd31;
      end
   end

   always_comb begin
      cur     = copy[FieldWeekday];
      limit   = 8'd6;
      wrap_to = 8'd0;
      case (field)
         FieldYear: begin
            cur   = copy[FieldYear];
            limit = 8'd99;
         end
         FieldMonth: begin
            cur     = copy[FieldMonth];
            limit   = 8'd12;
            wrap_to = 8'd1;
         end
         FieldDay: begin
            cur     = copy[FieldDay];
            limit   = day_limit;
            wrap_to = 8'd1;
         end
         FieldHour: begin
            cur   = copy[FieldHour];
            limit = 8'd23;
         end
         FieldMinute: begin
            cur   = copy[FieldMinute];
            limit = 8'd59;
         end
         FieldSecond: begin
            cur   = copy[FieldSecond];
            limit = 8'd59;
         end
         default: begin
            cur     = copy[FieldWeekday];
            limit   = 8'd6;
            wrap_to = 8'd0;
         end
      endcase
   end

   always_comb begin
      next_val = bcd_value(cur) + 8'd1;
      if (next_val > limit) begin
         next_val = wrap_to;
      end
   end

   assign bumped = to_bcd(next_val[6:0]);

endmodule

`default_nettype wire

// File: rtl/clts_blink.sv
`default_nettype none

module clts_blink
   import clts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_write_type csr,
   input  wire logic          advance,
   output logic               phase
);

   logic [7:0]  step_ff,  step_in;
   logic [15:0] limit_ff, limit_in;
   logic [15:0] count_ff, count_in;
   logic        state_ff, state_in;
   logic [16:0] sum;

   assign sum = {1'b0, count_ff} + 17'(step_ff);

   always_comb begin
      step_in  = step_ff;
      limit_in = limit_ff;
      count_in = count_ff;
      state_in = state_ff;
      if (csr.we) begin
         case (csr.index)
            RegBlinkStep:  step_in  = csr.data[7:0];
            RegBlinkLimit: limit_in = csr.data[15:0];
            default: ;
         endcase
      end
      if (advance) begin
         if (sum >= {1'b0, limit_ff}) begin
            count_in = '0;
            state_in = ~state_ff;
         end else begin
            count_in = sum[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= BlinkStepReset;
         limit_ff <= BlinkLimitReset;
         count_ff <= '0;
         state_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         limit_ff <= limit_in;
         count_ff <= count_in;
         state_ff <= state_in;
      end
   end

   assign phase = state_ff;

endmodule

`default_nettype wire

// File: rtl/clock_time_setting_controller.sv
`default_nettype none

// Time setting controller for a BCD real time clock display.
// req_ channel: one word per polling tick with the UP and SET button levels
//   and the seven raw BCD bytes read from the clock.
// rsp_ channel: one word per request word with the edit mode, selected field,
//   blink phase, save strobe and the seven bytes to show (edit copy while
//   editing or saving, else the clock bytes passed through).
// csr_ port: index 0 blink step, index 1 blink limit; write while idle.
// Datapath: an accepted word waits in the input register; its result goes
//   to the result register once that can take it. One word per cycle while
//   rsp_tready is high; all per-tick work is one combinational pass.
// Reset: edit mode off, field 0, button history low, blink counter and phase
//   cleared, blink step 20 and limit 250; both registers empty.
// Stall: a held result keeps the input register full; req_tready then drops
//   and no word is lost.

module clock_time_setting_controller
   import clts_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // up_pressed, set_pressed, rtc_second, rtc_minute, rtc_hour, rtc_day,
   // rtc_month, rtc_weekday, rtc_year, zero fill
   input  wire logic [63:0]              req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // editing, field_index[2:0], blink_phase, save_strobe, shown_second,
   // shown_minute, shown_hour, shown_day, shown_month, shown_weekday,
   // shown_year, zero fill
   output logic [63:0]                   rsp_tdata,
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   logic                  req_valid_ff, req_valid_in;
   req_word_type          req_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_ff;
   logic                  edit_mode_ff, edit_mode_in;
   logic [FieldWidth-1:0] edit_field_ff, edit_field_in;
   copy_type              edit_copy_ff, edit_copy_in;
   logic                  last_up_ff, last_set_ff;

   logic                  fire;
   logic                  set_edge, up_edge, save;
   copy_type              copy_after_set;
   bcd_type               bumped;
   logic                  phase;
   csr_write_type         csr;
   rsp_word_type          rsp_word;

   assign fire         = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !req_valid_ff || fire;
   assign req_valid_in = (req_tvalid && req_tready) || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   assign set_edge = req_ff.set_pressed && !last_set_ff;
   assign up_edge  = req_ff.up_pressed && !last_up_ff;

   always_comb begin
      edit_mode_in   = edit_mode_ff;
      edit_field_in  = edit_field_ff;
      copy_after_set = edit_copy_ff;
      save           = 1'b0;
      if (set_edge) begin
         if (!edit_mode_ff) begin
            edit_mode_in                 = 1'b1;
            edit_field_in                = FieldYear;
            copy_after_set[FieldYear]    = req_ff.rtc_year;
            copy_after_set[FieldMonth]   = req_ff.rtc_month;
            copy_after_set[FieldDay]     = req_ff.rtc_day;
            copy_after_set[FieldHour]    = req_ff.rtc_hour;
            copy_after_set[FieldMinute]  = req_ff.rtc_minute;
            copy_after_set[FieldSecond]  = req_ff.rtc_second;
            copy_after_set[FieldWeekday] = req_ff.rtc_weekday;
         end else if (edit_field_ff >= LastField) begin
            edit_mode_in  = 1'b0;
            edit_field_in = FieldYear;
            save          = 1'b1;
         end else begin
            edit_field_in = edit_field_ff + 3'd1;
         end
      end
   end

   clts_bump u_bump (
      .copy   (copy_after_set),
      .field  (edit_field_in),
      .bumped (bumped)
   );

   always_comb begin
      edit_copy_in = copy_after_set;
      if (up_edge && edit_mode_in) begin
         case (edit_field_in)
            FieldYear:    edit_copy_in[FieldYear]    = bumped;
            FieldMonth:   edit_copy_in[FieldMonth]   = bumped;
            FieldDay:     edit_copy_in[FieldDay]     = bumped;
            FieldHour:    edit_copy_in[FieldHour]    = bumped;
            FieldMinute:  edit_copy_in[FieldMinute]  = bumped;
            FieldSecond:  edit_copy_in[FieldSecond]  = bumped;
            default:      edit_copy_in[FieldWeekday] = bumped;
         endcase
      end
   end

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   clts_blink u_blink (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .advance (fire),
      .phase   (phase)
   );

   always_comb begin
      rsp_word             = '0;
      rsp_word.editing     = edit_mode_in;
      rsp_word.field_index = edit_field_in;
      rsp_word.blink_phase = phase;
      rsp_word.save_strobe = save;
      if (edit_mode_in || save) begin
         rsp_word.shown_second  = edit_copy_in[FieldSecond];
         rsp_word.shown_minute  = edit_copy_in[FieldMinute];
         rsp_word.shown_hour    = edit_copy_in[FieldHour];
         rsp_word.shown_day     = edit_copy_in[FieldDay];
         rsp_word.shown_month   = edit_copy_in[FieldMonth];
         rsp_word.shown_weekday = edit_copy_in[FieldWeekday];
         rsp_word.shown_year    = edit_copy_in[FieldYear];
      end else begin
         rsp_word.shown_second  = req_ff.rtc_second;
         rsp_word.shown_minute  = req_ff.rtc_minute;
         rsp_word.shown_hour    = req_ff.rtc_hour;
         rsp_word.shown_day     = req_ff.rtc_day;
         rsp_word.shown_month   = req_ff.rtc_month;
         rsp_word.shown_weekday = req_ff.rtc_weekday;
         rsp_word.shown_year    = req_ff.rtc_year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         edit_mode_ff  <= 1'b0;
         edit_field_ff <= FieldYear;
         last_up_ff    <= 1'b0;
         last_set_ff   <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            edit_mode_ff  <= edit_mode_in;
            edit_field_ff <= edit_field_in;
            last_up_ff    <= req_ff.up_pressed;
            last_set_ff   <= req_ff.set_pressed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_word_type'(req_tdata);
      end
      if (fire) begin
         rsp_ff       <= rsp_word;
         edit_copy_ff <= edit_copy_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      edit_field_ff <= LastField)
      else $error("edit field out of range");

   a_idle_field: assert property (@(posedge clock) disable iff (reset)
      !edit_mode_ff |-> edit_field_ff == FieldYear)
      else $error("field not cleared outside edit mode");

   a_save_leaves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.save_strobe |-> !rsp_ff.editing && !edit_mode_ff)
      else $error("save without leaving edit mode");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed word produced no result");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import clts_pkg::*;
;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // up_pressed, set_pressed, rtc_second, rtc_minute, rtc_hour, rtc_day,
   // rtc_month, rtc_weekday, rtc_year, zero fill
   logic [63:0]              req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // editing, field_index[2:0], blink_phase, save_strobe, shown_second,
   // shown_minute, shown_hour, shown_day, shown_month, shown_weekday,
   // shown_year, zero fill
   logic [63:0]              rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   clock_time_setting_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted controller state
   logic                  edit_on = 1'b0;
   logic [FieldWidth-1:0] cur_field = FieldYear;
   logic [7:0]            edit_bytes [NumFields] = '{default: 8'h00};
   logic                  prev_up = 1'b0;
   logic                  old_set = 1'b0;
   logic                  phase = 1'b0;
   int unsigned           blink_acc = 0;
   logic [7:0]            cfg_step = BlinkStepReset;
   logic [15:0]           cfg_limit = BlinkLimitReset;

   rsp_word_type expected_display [$];
   int           fail_count = 0;
   int           ticks_sent = 0;
   bit           idle_on = 1'b1;
   bit           fixed_rtc = 1'b0;
   req_word_type rtc_fixed = '0;
   int           stall_left = 0;

   function automatic int bcd_to_int(input logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
   endfunction

   function automatic logic [7:0] int_to_bcd(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic logic [7:0] bcd_bump(input logic [7:0] b, input int lim, input int wrap);
      int v;
      v = bcd_to_int(b) + 1;
      if (v > lim) v = wrap;
      return int_to_bcd(v);
   endfunction

   function automatic int month_length(input logic [7:0] mon, input logic [7:0] yr);
      int m;
      int y;
      m = bcd_to_int(mon);
      y = 2000 + bcd_to_int(yr);
      if (m == 2) return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   function automatic rsp_word_type compute_display(input req_word_type w);
      rsp_word_type r;
      logic         saving;
      logic         old_phase;
      saving = 1'b0;
      if (w.set_pressed && !old_set) begin
         if (!edit_on) begin
            edit_on = 1'b1;
            cur_field = FieldYear;
            edit_bytes[FieldYear]    = w.rtc_year;
            edit_bytes[FieldMonth]   = w.rtc_month;
            edit_bytes[FieldDay]     = w.rtc_day;
            edit_bytes[FieldHour]    = w.rtc_hour;
            edit_bytes[FieldMinute]  = w.rtc_minute;
            edit_bytes[FieldSecond]  = w.rtc_second;
            edit_bytes[FieldWeekday] = w.rtc_weekday;
         end else if (cur_field >= LastField) begin
            edit_on = 1'b0;
            cur_field = FieldYear;
            saving = 1'b1;
         end else begin
            cur_field = cur_field + 3'd1;
         end
      end
      if (w.up_pressed && !prev_up && edit_on) begin
         case (cur_field)
            FieldYear:   edit_bytes[FieldYear] = bcd_bump(edit_bytes[FieldYear], 99, 0);
            FieldMonth:  edit_bytes[FieldMonth] = bcd_bump(edit_bytes[FieldMonth], 12, 1);
            FieldDay:    edit_bytes[FieldDay] = bcd_bump(edit_bytes[FieldDay],
                            month_length(edit_bytes[FieldMonth], edit_bytes[FieldYear]), 1);
            FieldHour:   edit_bytes[FieldHour] = bcd_bump(edit_bytes[FieldHour], 23, 0);
            FieldMinute: edit_bytes[FieldMinute] = bcd_bump(edit_bytes[FieldMinute], 59, 0);
            FieldSecond: edit_bytes[FieldSecond] = bcd_bump(edit_bytes[FieldSecond], 59, 0);
            default:     edit_bytes[FieldWeekday] = bcd_bump(edit_bytes[FieldWeekday], 6, 0);
         endcase
      end
      prev_up = w.up_pressed;
      old_set = w.set_pressed;

      old_phase = phase;
      blink_acc = blink_acc + cfg_step;
      if (blink_acc >= cfg_limit) begin
         blink_acc = 0;
         phase = !phase;
      end
      blink_acc = blink_acc & 32'hFFFF;

      r = '0;
      r.editing = edit_on;
      r.field_index = cur_field;
      r.blink_phase = old_phase;
      r.save_strobe = saving;
      if (edit_on || saving) begin
         r.shown_second  = edit_bytes[FieldSecond];
         r.shown_minute  = edit_bytes[FieldMinute];
         r.shown_hour    = edit_bytes[FieldHour];
         r.shown_day     = edit_bytes[FieldDay];
         r.shown_month   = edit_bytes[FieldMonth];
         r.shown_weekday = edit_bytes[FieldWeekday];
         r.shown_year    = edit_bytes[FieldYear];
      end else begin
         r.shown_second  = w.rtc_second;
         r.shown_minute  = w.rtc_minute;
         r.shown_hour    = w.rtc_hour;
         r.shown_day     = w.rtc_day;
         r.shown_month   = w.rtc_month;
         r.shown_weekday = w.rtc_weekday;
         r.shown_year    = w.rtc_year;
      end
      return r;
   endfunction

   // mostly legal BCD, sometimes a raw byte
   function automatic logic [7:0] rand_bcd(input int lo, input int hi);
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return int_to_bcd($urandom_range(lo, hi));
   endfunction

   function automatic req_word_type random_time();
      req_word_type w;
      w = '0;
      w.rtc_second  = rand_bcd(0, 59);
      w.rtc_minute  = rand_bcd(0, 59);
      w.rtc_hour    = rand_bcd(0, 23);
      w.rtc_day     = rand_bcd(1, 31);
      w.rtc_month   = rand_bcd(1, 12);
      w.rtc_weekday = rand_bcd(0, 6);
      w.rtc_year    = rand_bcd(0, 99);
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      expected_display.push_back(compute_display(w));
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic tick(input logic up, input logic set);
      req_word_type w;
      if (fixed_rtc) w = rtc_fixed;
      else w = random_time();
      w.up_pressed = up;
      w.set_pressed = set;
      w.pad = '0;
      send_word(w);
   endtask

   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (expected_display.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == RegBlinkStep) cfg_step = value[7:0];
      else cfg_limit = value;
      @(negedge clock);
   endtask

   task automatic set_time(input logic [7:0] yr, input logic [7:0] mon, input logic [7:0] day,
                           input logic [7:0] hr, input logic [7:0] mins,
                           input logic [7:0] sec, input logic [7:0] wd);
      rtc_fixed = '0;
      rtc_fixed.rtc_year = yr;
      rtc_fixed.rtc_month = mon;
      rtc_fixed.rtc_day = day;
      rtc_fixed.rtc_hour = hr;
      rtc_fixed.rtc_minute = mins;
      rtc_fixed.rtc_second = sec;
      rtc_fixed.rtc_weekday = wd;
   endtask

   // pass-through of extreme bytes, then every field edited at its wrap point
   task automatic test_passthrough_and_wraps();
      fixed_rtc = 1'b1;
      set_time(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      tick(1'b0, 1'b0);
      set_time(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      tick(1'b0, 1'b0);
      set_time(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59, 8'h06);
      tick(1'b0, 1'b1);
      for (int f = 0; f < NumFields; f++) begin
         tick(1'b1, 1'b0);
         tick(1'b0, 1'b1);
      end
      tick(1'b0, 1'b0);
   endtask

   // both edges entering edit mode roll 99 to 00, so February 2000 gets 29 days
   task automatic test_leap_day();
      fixed_rtc = 1'b1;
      set_time(8'h99, 8'h02, 8'h28, 8'h12, 8'h30, 8'h00, 8'h02);
      tick(1'b1, 1'b1);
      tick(1'b0, 1'b0);
      tick(1'b0, 1'b1);
      tick(1'b0, 1'b0);
      tick(1'b0, 1'b1);
      tick(1'b1, 1'b0);
      tick(1'b0, 1'b0);
      tick(1'b1, 1'b0);
      tick(1'b0, 1'b0);
      fixed_rtc = 1'b0;
   endtask

   task automatic run_session();
      int presses;
      tick(1'b0, 1'b1);
      tick(1'b0, 1'b0);
      for (int f = 0; f < NumFields; f++) begin
         presses = $urandom_range(0, 3);
         repeat (presses) begin
            tick(1'b1, 1'b0);
            tick(1'b0, 1'b0);
         end
         tick(($urandom_range(0, 7) == 0), 1'b1);
         tick(1'b0, 1'b0);
      end
   endtask

   task automatic test_edit_sessions(input logic [7:0] step, input logic [15:0] limit,
                                     input int count);
      int target;
      int burst;
      settle_idle();
      write_reg(RegBlinkStep, {8'h00, step});
      write_reg(RegBlinkLimit, limit);
      fixed_rtc = 1'b0;
      target = ticks_sent + count;
      while (ticks_sent < target) begin
         if ($urandom_range(0, 9) < 7) begin
            run_session();
         end else begin
            burst = $urandom_range(1, 8);
            repeat (burst) tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_display.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result word %h", got);
         end else begin
            want = expected_display.pop_front();
            if (got.editing !== want.editing || got.field_index !== want.field_index ||
                got.blink_phase !== want.blink_phase ||
                got.save_strobe !== want.save_strobe ||
                got.shown_second !== want.shown_second ||
                got.shown_minute !== want.shown_minute ||
                got.shown_hour !== want.shown_hour || got.shown_day !== want.shown_day ||
                got.shown_month !== want.shown_month ||
                got.shown_weekday !== want.shown_weekday ||
                got.shown_year !== want.shown_year || got.pad !== want.pad) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("exp: ed=%0d fld=%0d blk=%0d sv=%0d y%h m%h d%h %h:%h:%h wd%h",
                           want.editing, want.field_index, want.blink_phase, want.save_strobe,
                           want.shown_year, want.shown_month, want.shown_day, want.shown_hour,
                           want.shown_minute, want.shown_second, want.shown_weekday);
                  $display("got: ed=%0d fld=%0d blk=%0d sv=%0d y%h m%h d%h %h:%h:%h wd%h p%0d",
                           got.editing, got.field_index, got.blink_phase, got.save_strobe,
                           got.shown_year, got.shown_month, got.shown_day, got.shown_hour,
                           got.shown_minute, got.shown_second, got.shown_weekday, got.pad);
               end
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_passthrough_and_wraps();
      test_leap_day();
      test_edit_sessions(8'd255, 16'd1, 100);
      test_edit_sessions(8'd1, 16'd65535, 100);
      test_edit_sessions(8'($urandom_range(1, 255)), 16'($urandom_range(1, 1000)), 100);
      test_edit_sessions(8'd1, 16'd1, 100);
      test_edit_sessions(8'd255, 16'd65535, 90);
      idle_on <= 1'b0;
      test_edit_sessions(8'd20, 16'd250, 130);
      settle_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && expected_display.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/clts_pkg.sv
rtl/clts_bump.sv
rtl/clts_blink.sv
rtl/clock_time_setting_controller.sv
tb/tb_top.sv
